>>> hw/rtl/fdt_pkg.sv
package fdt_pkg;

   // Defaults for the top-level parameters
   localparam int TABLE_ENTRIES_DEFAULT = 14;
   localparam int COUNT_BITS_DEFAULT    = 10;

   // Control/status register port
   localparam int CSR_DATA_BITS  = 10;
   localparam int CSR_INDEX_BITS = 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SAMPLE_CUTOFF    = 1'b0,
      CSR_SATURATION_POINT = 1'b1
   } csr_index_type;

   localparam logic [CSR_DATA_BITS-1:0] SAMPLE_CUTOFF_RESET    = 10'd100;
   localparam logic [CSR_DATA_BITS-1:0] SATURATION_POINT_RESET = 10'd1023;

   // Request opcodes
   typedef enum logic {
      OP_UPDATE = 1'b0,
      OP_QUERY  = 1'b1
   } opcode_type;

   localparam int DISTANCE_BITS = 4;

   // Decoded request, held in the input register
   typedef struct packed {
      logic       valid;
      opcode_type opcode;
      logic       bad_distance;
   } op_type;

endpackage

>>> hw/rtl/fdt_decode.sv
// Maps a signed distance to a table slot and flags zero / out-of-range values.
module fdt_decode #(
   parameter int TABLE_ENTRIES = fdt_pkg::TABLE_ENTRIES_DEFAULT,
   localparam int IDX_BITS     = $clog2(TABLE_ENTRIES)
) (
   input  logic signed [fdt_pkg::DISTANCE_BITS-1:0] distance,
   output logic [IDX_BITS-1:0]                     index,
   output logic                                    bad_distance
);

   localparam int HalfSpan = TABLE_ENTRIES / 2;

   int dist_int;
   int idx_int;

   always_comb begin
      dist_int = int'(distance);
      // negative distances fill the low half, positive the high half
      if (dist_int < 0) begin
         idx_int = dist_int + HalfSpan;
      end else begin
         idx_int = dist_int + HalfSpan - 1;
      end
      bad_distance = (dist_int == 0) || (dist_int < -HalfSpan) || (dist_int > HalfSpan)
                     || (idx_int < 0) || (idx_int >= TABLE_ENTRIES);
      index = idx_int[IDX_BITS-1:0];
   end

endmodule

>>> hw/rtl/fdt_table.sv
// Counter table: increment with saturation, global halving, threshold query.
module fdt_table #(
   parameter int TABLE_ENTRIES = fdt_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int COUNT_BITS    = fdt_pkg::COUNT_BITS_DEFAULT,
   localparam int IDX_BITS     = $clog2(TABLE_ENTRIES)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  fdt_pkg::op_type                    op,
   input  logic [IDX_BITS-1:0]                index,
   input  logic [fdt_pkg::CSR_DATA_BITS-1:0]  sample_cutoff,
   input  logic [fdt_pkg::CSR_DATA_BITS-1:0]  saturation_point,
   output logic                               rsp_valid,
   output logic                               rsp_to_sampler,
   output logic                               rsp_bad_distance
);

   localparam int CmpBits = (COUNT_BITS > fdt_pkg::CSR_DATA_BITS) ?
                            COUNT_BITS : fdt_pkg::CSR_DATA_BITS;
   localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

   logic [COUNT_BITS-1:0] counts_ff [TABLE_ENTRIES];
   logic [COUNT_BITS-1:0] counts_in [TABLE_ENTRIES];
   logic                  valid_ff, valid_in;
   logic                  to_sampler_ff, to_sampler_in;
   logic                  bad_ff, bad_in;

   logic [COUNT_BITS-1:0] cur_count;
   logic [COUNT_BITS-1:0] inc_count;
   logic [CmpBits-1:0]    cur_wide;
   logic [CmpBits-1:0]    inc_wide;
   logic                  do_update;
   logic                  halve;

   always_comb begin
      cur_count = counts_ff[index];
      inc_count = (cur_count < CountMax) ? cur_count + 1'b1 : cur_count;
      cur_wide  = CmpBits'(cur_count);
      inc_wide  = CmpBits'(inc_count);
      do_update = op.valid && !op.bad_distance && (op.opcode == fdt_pkg::OP_UPDATE);
      halve     = do_update && (inc_wide == CmpBits'(saturation_point));

      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         counts_in[i] = (do_update && (index == IDX_BITS'(i))) ? inc_count : counts_ff[i];
         if (halve) begin
            counts_in[i] = counts_in[i] >> 1;
         end
      end

      valid_in      = op.valid;
      bad_in        = op.bad_distance;
      to_sampler_in = op.valid && !op.bad_distance && (op.opcode == fdt_pkg::OP_QUERY)
                      && (cur_wide < CmpBits'(sample_cutoff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            counts_ff[i] <= '0;
         end
         valid_ff <= 1'b0;
      end else begin
         counts_ff <= counts_in;
         valid_ff  <= valid_in;
      end
      to_sampler_ff <= to_sampler_in;
      bad_ff        <= bad_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_to_sampler   = to_sampler_ff;
   assign rsp_bad_distance = bad_ff;

endmodule

>>> hw/rtl/free_distance_table_top.sv
// A taken request passes two stages: the request register, then the table update /
// response register, which drives the response strobe.
// Throughput: one request per cycle; busy is low except during reset.
// Reset (synchronous, active high) clears all counters, loads threshold 100 and
// saturation point 1023, and drops the response strobe.
// The response is held for exactly one cycle; the receiver cannot stall it.
module free_distance_table_top #(
   parameter int TABLE_ENTRIES = fdt_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int COUNT_BITS    = fdt_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    start,
   output logic                                    busy,
   input  logic                                    req_opcode,
   input  logic signed [fdt_pkg::DISTANCE_BITS-1:0] req_distance,
   // response channel
   output logic                                    rsp_valid,
   output logic                                    rsp_to_sampler,
   output logic                                    rsp_bad_distance,
   // register write port
   input  logic                                    csr_we,
   input  logic [fdt_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [fdt_pkg::CSR_DATA_BITS-1:0]       csr_wdata
);

   localparam int IdxBits = $clog2(TABLE_ENTRIES);

   // Config registers
   logic [fdt_pkg::CSR_DATA_BITS-1:0] threshold_ff, threshold_in;
   logic [fdt_pkg::CSR_DATA_BITS-1:0] sat_point_ff, sat_point_in;

   // Request register (decoded)
   fdt_pkg::op_type       op_ff, op_in;
   logic [IdxBits-1:0]    index_ff, index_in;

   logic                  accept;
   logic                  dec_bad;
   logic [IdxBits-1:0]    dec_index;

   // No back-pressure: a transfer is taken in every cycle outside reset in which start is high.
   assign busy   = reset;
   assign accept = start && !busy;

   fdt_decode #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_decode (
      .distance     (req_distance),
      .index        (dec_index),
      .bad_distance (dec_bad)
   );

   always_comb begin
      op_in.valid        = accept;
      op_in.opcode       = fdt_pkg::opcode_type'(req_opcode);
      op_in.bad_distance = dec_bad;
      index_in           = dec_index;

      threshold_in = threshold_ff;
      sat_point_in = sat_point_ff;
      if (csr_we) begin
         unique case (fdt_pkg::csr_index_type'(csr_index))
            fdt_pkg::CSR_SAMPLE_CUTOFF:    threshold_in = csr_wdata;
            fdt_pkg::CSR_SATURATION_POINT: sat_point_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= fdt_pkg::SAMPLE_CUTOFF_RESET;
         sat_point_ff <= fdt_pkg::SATURATION_POINT_RESET;
         op_ff.valid  <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         sat_point_ff <= sat_point_in;
         op_ff.valid  <= op_in.valid;
      end
      // payload, no reset needed
      op_ff.opcode       <= op_in.opcode;
      op_ff.bad_distance <= op_in.bad_distance;
      index_ff           <= index_in;
   end

   // Table stage: reads the slot combinationally and writes it at the same clock edge, so back-to-back
   // requests on the same distance always see the previous update.
   fdt_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .COUNT_BITS    (COUNT_BITS)
   ) u_table (
      .clock              (clock),
      .reset              (reset),
      .op                 (op_ff),
      .index              (index_ff),
      .sample_cutoff      (threshold_ff),
      .saturation_point   (sat_point_ff),
      .rsp_valid          (rsp_valid),
      .rsp_to_sampler     (rsp_to_sampler),
      .rsp_bad_distance   (rsp_bad_distance)
   );

endmodule
